// ===== rtl/pse_pkg.sv =====
// Shared constants, types and helper functions of the polyline stroke expander.
package pse_pkg;

  // Point and vertex coordinates: two's complement, 8 fraction bits
  localparam int unsigned CoordW   = 24;
  // Vertex sum before saturation: coordinate plus a signed offset
  localparam int unsigned SumW     = CoordW + 2;
  // |dx| and |dy| fit in the coordinate width
  localparam int unsigned MagW     = CoordW;
  localparam int unsigned ProdW    = 2 * MagW;
  // Sum of squares: strictly below 2^49
  localparam int unsigned Dist2W   = ProdW + 1;
  // Radicand is the sum of squares shifted up by 14 bits
  localparam int unsigned RootFrac = 14;
  localparam int unsigned RootW    = 32;
  localparam int unsigned SrcW     = 2 * RootW;
  localparam int unsigned RemW     = RootW + 2;

  // Register widths
  localparam int unsigned WidthW   = 16;
  localparam int unsigned ColorW   = 32;
  localparam int unsigned TexW     = 16;
  localparam int unsigned IndexW   = 32;

  // |c| * width stays below 2^40, times 64 plus the rounding term below 2^47
  localparam int unsigned ScaleW   = MagW + WidthW;
  localparam int unsigned ScaleSh  = 6;
  localparam int unsigned DivW     = ScaleW + ScaleSh + 1;
  // Offset magnitude never exceeds half the width plus one
  localparam int unsigned QuotW    = 17;
  localparam int unsigned OffW     = QuotW;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] RegStrokeWidth = 2'd0;
  localparam logic [CfgIdxW-1:0] RegStrokeColor = 2'd1;
  localparam logic [CfgIdxW-1:0] RegWhiteU      = 2'd2;
  localparam logic [CfgIdxW-1:0] RegWhiteV      = 2'd3;

  localparam logic [WidthW-1:0] StrokeWidthRst = 16'd256;
  localparam logic [ColorW-1:0] StrokeColorRst = 32'hFFFF_FFFF;
  localparam logic [TexW-1:0]   WhiteURst      = 16'd0;
  localparam logic [TexW-1:0]   WhiteVRst      = 16'd0;

  // Record kinds
  localparam logic KindVertex = 1'b0;
  localparam logic KindIndex  = 1'b1;

  // Records per segment: four vertices, then six indices
  localparam int unsigned NumVerts  = 4;
  localparam int unsigned NumRecs   = 10;
  localparam int unsigned RecCntW   = 4;

  // Commands to the shared root/divide unit
  typedef struct packed {
    logic root;
    logic div;
  } rdu_cmd_t;

  // Offset of index record k from the segment's base vertex
  function automatic logic [1:0] tri_ofs(input logic [2:0] k);
    logic [1:0] r;
    unique case (k)
      3'd0:    r = 2'd0;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd0;
      3'd4:    r = 2'd2;
      3'd5:    r = 2'd3;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // Clamp a vertex sum to the coordinate range
  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    logic signed [CoordW-1:0] r;
    hi = SumW'((2 ** (CoordW - 1)) - 1);
    lo = -hi - SumW'(1);
    if (v > hi) begin
      r = hi[CoordW-1:0];
    end else if (v < lo) begin
      r = lo[CoordW-1:0];
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/pse_if.sv =====
// Valid/ready channel interfaces for input points and output records.
interface pse_point_if;
  logic                                valid;
  logic                                ready;
  logic signed [pse_pkg::CoordW-1:0]   point_x;
  logic signed [pse_pkg::CoordW-1:0]   point_y;
  logic                                path_start;

  modport source (output valid, point_x, point_y, path_start, input ready);
  modport sink   (input valid, point_x, point_y, path_start, output ready);
endinterface

interface pse_record_if;
  logic                                valid;
  logic                                ready;
  logic                                record_kind;
  logic signed [pse_pkg::CoordW-1:0]   vert_x;
  logic signed [pse_pkg::CoordW-1:0]   vert_y;
  logic [pse_pkg::TexW-1:0]            vert_u;
  logic [pse_pkg::TexW-1:0]            vert_v;
  logic [pse_pkg::ColorW-1:0]          vert_color;
  logic [pse_pkg::IndexW-1:0]          index_value;
  logic                                last_of_segment;

  modport source (output valid, record_kind, vert_x, vert_y, vert_u, vert_v, vert_color,
                  index_value, last_of_segment, input ready);
  modport sink   (input valid, record_kind, vert_x, vert_y, vert_u, vert_v, vert_color,
                  index_value, last_of_segment, output ready);
endinterface

// ===== rtl/pse_smul.sv =====
// Two-lane bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module pse_smul (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic [1:0][pse_pkg::MagW-1:0]           a_i,
  input  logic [1:0][pse_pkg::MagW-1:0]           b_i,
  output logic                                    done_o,
  output logic [1:0][pse_pkg::ProdW-1:0]          prod_o
);

  localparam int unsigned CntW = $clog2(pse_pkg::MagW);

  logic [1:0][pse_pkg::ProdW-1:0] prod_q, prod_d;
  logic [1:0][pse_pkg::MagW-1:0]  a_q;
  logic [CntW-1:0]                cnt_q;
  logic                           busy_q;
  logic                           done_q;
  logic [1:0][pse_pkg::MagW:0]    sum;

  // Add the multiplicand into the upper half when the low bit is set, then shift right
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sum[l] = {1'b0, prod_q[l][pse_pkg::ProdW-1:pse_pkg::MagW]}
             + (prod_q[l][0] ? {1'b0, a_q[l]} : '0);
      prod_d[l] = {sum[l], prod_q[l][pse_pkg::MagW-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(pse_pkg::MagW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int l = 0; l < 2; l++) begin
        prod_q[l] <= {{pse_pkg::MagW{1'b0}}, b_i[l]};
        a_q[l]    <= a_i[l];
      end
    end else if (busy_q) begin
      prod_q <= prod_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

// ===== rtl/pse_rdu.sv =====
// Shared digit-serial unit: restoring square root (2 radicand bits a cycle) and division.
module pse_rdu (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pse_pkg::rdu_cmd_t             cmd_i,
  input  logic [pse_pkg::SrcW-1:0]      radicand_i,
  input  logic [pse_pkg::DivW-1:0]      dividend_i,
  input  logic [pse_pkg::RootW-1:0]     divisor_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [pse_pkg::RootW-1:0]     result_o
);

  localparam int unsigned CntW = $clog2(pse_pkg::RootW);
  localparam int unsigned TopW = pse_pkg::DivW - pse_pkg::QuotW;

  logic [pse_pkg::RemW-1:0]  rem_q;
  logic [pse_pkg::RootW-1:0] res_q;
  logic [pse_pkg::SrcW-1:0]  src_q;
  logic [CntW-1:0]           cnt_q;
  logic                      root_q;
  logic                      busy_q;
  logic                      done_q;

  logic [pse_pkg::RemW-1:0]  rem_sh;
  logic [pse_pkg::RemW-1:0]  operand;
  logic [pse_pkg::RemW:0]    diff;
  logic                      fits;
  logic                      last;

  always_comb begin
    if (root_q) begin
      rem_sh  = {rem_q[pse_pkg::RemW-3:0], src_q[pse_pkg::SrcW-1 -: 2]};
      operand = {res_q, 2'b01};
      last    = (cnt_q == CntW'(pse_pkg::RootW - 1));
    end else begin
      rem_sh  = {rem_q[pse_pkg::RemW-2:0], src_q[pse_pkg::SrcW-1]};
      operand = {2'b00, divisor_i};
      last    = (cnt_q == CntW'(pse_pkg::QuotW - 1));
    end
    diff = {1'b0, rem_sh} - {1'b0, operand};
    fits = !diff[pse_pkg::RemW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      root_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      priority if (cmd_i.root) begin
        busy_q <= 1'b1;
        root_q <= 1'b1;
        cnt_q  <= '0;
      end else if (cmd_i.div) begin
        busy_q <= 1'b1;
        root_q <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (cmd_i.root) begin
      rem_q <= '0;
      res_q <= '0;
      src_q <= radicand_i;
    end else if (cmd_i.div) begin
      // Quotient fits in QuotW bits, so the top bits start below the divisor
      rem_q <= {{(pse_pkg::RemW - TopW){1'b0}},
                dividend_i[pse_pkg::DivW-1:pse_pkg::QuotW]};
      res_q <= '0;
      src_q <= {dividend_i[pse_pkg::QuotW-1:0], {(pse_pkg::SrcW - pse_pkg::QuotW){1'b0}}};
    end else if (busy_q) begin
      rem_q <= fits ? diff[pse_pkg::RemW-1:0] : rem_sh;
      res_q <= {res_q[pse_pkg::RootW-2:0], fits};
      src_q <= root_q ? {src_q[pse_pkg::SrcW-3:0], 2'b00} : {src_q[pse_pkg::SrcW-2:0], 1'b0};
    end
  end

  assign busy_o   = busy_q;
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== rtl/polyline_stroke_expander.sv =====
// Polyline stroke expander: turns polyline points into quad vertices and triangle indices.
//
// point_i takes one point per word (x, y, path_start). A path-start point, or any point
// before the first one, is only latched. Every other point closes a segment and produces
// ten words on record_o: four vertex records, then six index records, the tenth flagged
// last_of_segment. From acceptance to the last record loaded, a segment passes through a
// 24-step bit-serial multiply for the squares, a 32-step square root, a 24-step multiply
// by the width and two 17-step divisions on the shared root/divide unit, then loads one
// record a cycle while the output register is free. A zero-length segment skips the
// root, the multiply by the width and the divisions.
// point_i.ready is high only while the block is idle; the last record may still wait
// in the output register while the next point is accepted.
// If record_o stalls, the record held in the output register stays stable and record
// generation pauses. Configuration writes on cfg_* take effect at the next edge and are
// meant for idle periods. Reset clears the previous point, the vertex counter and the
// output valid, and loads the register defaults (width 1.0, white opaque colour, uv 0).
module polyline_stroke_expander (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pse_point_if.sink                      point_i,
  pse_record_if.source                   record_o,
  input  logic                           cfg_we_i,
  input  logic [pse_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pse_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned StW = 3;
  localparam logic [StW-1:0] StIdle   = 3'd0;
  localparam logic [StW-1:0] StSquare = 3'd1;
  localparam logic [StW-1:0] StRoot   = 3'd2;
  localparam logic [StW-1:0] StScale  = 3'd3;
  localparam logic [StW-1:0] StDivX   = 3'd4;
  localparam logic [StW-1:0] StDivY   = 3'd5;
  localparam logic [StW-1:0] StEmit   = 3'd6;

  localparam int unsigned CW = pse_pkg::CoordW;

  // Configuration registers
  logic [pse_pkg::WidthW-1:0] width_q;
  logic [pse_pkg::ColorW-1:0] color_q;
  logic [pse_pkg::TexW-1:0]   white_u_q;
  logic [pse_pkg::TexW-1:0]   white_v_q;

  // Segment state
  logic [StW-1:0]                 state_q;
  logic signed [CW-1:0]           prev_x_q, prev_y_q;
  logic signed [CW-1:0]           cur_x_q, cur_y_q;
  logic                           have_prev_q;
  logic [pse_pkg::IndexW-1:0]     vcount_q;
  logic [pse_pkg::MagW-1:0]       adx_q, ady_q;
  logic                           neg_x_q, neg_y_q;
  logic [pse_pkg::RootW-1:0]      len_q;
  logic [pse_pkg::OffW-1:0]       offx_q, offy_q;
  logic [pse_pkg::RecCntW-1:0]    rec_q;

  // Output register
  logic                           out_valid_q;
  logic                           kind_q;
  logic signed [CW-1:0]           vx_q, vy_q;
  logic [pse_pkg::TexW-1:0]       vu_q, vv_q;
  logic [pse_pkg::ColorW-1:0]     vcolor_q;
  logic [pse_pkg::IndexW-1:0]     index_q;
  logic                           last_q;

  logic                           in_acc;
  logic                           seg_start;
  logic signed [CW:0]             dx_c, dy_c;
  logic [pse_pkg::MagW-1:0]       adx_c, ady_c;

  logic                           mul_start;
  logic [1:0][pse_pkg::MagW-1:0]  mul_a, mul_b;
  logic                           mul_done;
  logic [1:0][pse_pkg::ProdW-1:0] mul_prod;
  logic [pse_pkg::Dist2W-1:0]     dist2;

  pse_pkg::rdu_cmd_t              rdu_cmd;
  logic [pse_pkg::SrcW-1:0]       radicand;
  logic [pse_pkg::DivW-1:0]       dividend;
  logic                           rdu_busy;
  logic                           rdu_done;
  logic [pse_pkg::RootW-1:0]      rdu_result;

  logic                           emit_load;
  logic signed [pse_pkg::OffW:0]  ox_s, oy_s;
  logic signed [CW-1:0]           base_x, base_y;
  logic signed [pse_pkg::SumW-1:0] sum_x, sum_y;
  logic [1:0]                     tri_k;
  logic                           rec_is_vert;
  logic                           rec_is_last;

  assign point_i.ready = (state_q == StIdle);
  assign in_acc        = point_i.valid && point_i.ready;
  assign seg_start     = in_acc && !point_i.path_start && have_prev_q;

  always_comb begin
    dx_c  = $signed({point_i.point_x[CW-1], point_i.point_x})
          - $signed({prev_x_q[CW-1], prev_x_q});
    dy_c  = $signed({point_i.point_y[CW-1], point_i.point_y})
          - $signed({prev_y_q[CW-1], prev_y_q});
    adx_c = dx_c[CW] ? pse_pkg::MagW'(-dx_c) : pse_pkg::MagW'(dx_c);
    ady_c = dy_c[CW] ? pse_pkg::MagW'(-dy_c) : pse_pkg::MagW'(dy_c);
  end

  // Multiplier: squares on segment start, then |c| * width after the root
  always_comb begin
    if (state_q == StIdle) begin
      mul_a[0] = adx_c;
      mul_b[0] = adx_c;
      mul_a[1] = ady_c;
      mul_b[1] = ady_c;
    end else begin
      mul_a[0] = adx_q;
      mul_b[0] = {{(pse_pkg::MagW - pse_pkg::WidthW){1'b0}}, width_q};
      mul_a[1] = ady_q;
      mul_b[1] = {{(pse_pkg::MagW - pse_pkg::WidthW){1'b0}}, width_q};
    end
    mul_start = seg_start || ((state_q == StRoot) && rdu_done);
  end

  pse_smul u_smul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  always_comb begin
    dist2    = {1'b0, mul_prod[0]} + {1'b0, mul_prod[1]};
    radicand = {{(pse_pkg::SrcW - pse_pkg::Dist2W - pse_pkg::RootFrac){1'b0}}, dist2,
                {pse_pkg::RootFrac{1'b0}}};
    // Numerator |c| * width * 64 plus half the length, for round to nearest
    dividend = {1'b0, mul_prod[state_q == StScale ? 0 : 1][pse_pkg::ScaleW-1:0],
                {pse_pkg::ScaleSh{1'b0}}}
             + pse_pkg::DivW'(len_q[pse_pkg::RootW-1:1]);
    rdu_cmd.root = (state_q == StSquare) && mul_done && (dist2 != '0);
    rdu_cmd.div  = ((state_q == StScale) && mul_done) || ((state_q == StDivX) && rdu_done);
  end

  pse_rdu u_rdu (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (rdu_cmd),
    .radicand_i (radicand),
    .dividend_i (dividend),
    .divisor_i  (len_q),
    .busy_o     (rdu_busy),
    .done_o     (rdu_done),
    .result_o   (rdu_result)
  );

  // Record generation
  always_comb begin
    emit_load   = (state_q == StEmit) && (!out_valid_q || record_o.ready);
    rec_is_vert = (rec_q < pse_pkg::RecCntW'(pse_pkg::NumVerts));
    rec_is_last = (rec_q == pse_pkg::RecCntW'(pse_pkg::NumRecs - 1));
    ox_s = neg_x_q ? -$signed({1'b0, offx_q}) : $signed({1'b0, offx_q});
    oy_s = neg_y_q ? -$signed({1'b0, offy_q}) : $signed({1'b0, offy_q});
    // Vertices 1 and 2 sit on the new point, 0 and 3 on the previous one
    if ((rec_q == pse_pkg::RecCntW'(1)) || (rec_q == pse_pkg::RecCntW'(2))) begin
      base_x = cur_x_q;
      base_y = cur_y_q;
    end else begin
      base_x = prev_x_q;
      base_y = prev_y_q;
    end
    if (rec_q < pse_pkg::RecCntW'(2)) begin
      sum_x = pse_pkg::SumW'(base_x) + pse_pkg::SumW'(oy_s);
      sum_y = pse_pkg::SumW'(base_y) - pse_pkg::SumW'(ox_s);
    end else begin
      sum_x = pse_pkg::SumW'(base_x) - pse_pkg::SumW'(oy_s);
      sum_y = pse_pkg::SumW'(base_y) + pse_pkg::SumW'(ox_s);
    end
    tri_k = pse_pkg::tri_ofs(3'(rec_q - pse_pkg::RecCntW'(pse_pkg::NumVerts)));
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= pse_pkg::StrokeWidthRst;
      color_q   <= pse_pkg::StrokeColorRst;
      white_u_q <= pse_pkg::WhiteURst;
      white_v_q <= pse_pkg::WhiteVRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pse_pkg::RegStrokeWidth: width_q   <= cfg_data_i[pse_pkg::WidthW-1:0];
        pse_pkg::RegStrokeColor: color_q   <= cfg_data_i[pse_pkg::ColorW-1:0];
        pse_pkg::RegWhiteU:      white_u_q <= cfg_data_i[pse_pkg::TexW-1:0];
        pse_pkg::RegWhiteV:      white_v_q <= cfg_data_i[pse_pkg::TexW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and model state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      have_prev_q <= 1'b0;
      vcount_q    <= '0;
      rec_q       <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_acc && !seg_start) begin
            prev_x_q    <= point_i.point_x;
            prev_y_q    <= point_i.point_y;
            have_prev_q <= 1'b1;
          end else if (seg_start) begin
            state_q <= StSquare;
          end
        end
        StSquare: begin
          if (mul_done) begin
            rec_q   <= '0;
            state_q <= (dist2 == '0) ? StEmit : StRoot;
          end
        end
        StRoot: begin
          if (rdu_done) begin
            state_q <= StScale;
          end
        end
        StScale: begin
          if (mul_done) begin
            state_q <= StDivX;
          end
        end
        StDivX: begin
          if (rdu_done) begin
            state_q <= StDivY;
          end
        end
        StDivY: begin
          if (rdu_done) begin
            rec_q   <= '0;
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (emit_load) begin
            rec_q <= rec_q + pse_pkg::RecCntW'(1);
            if (rec_is_last) begin
              prev_x_q <= cur_x_q;
              prev_y_q <= cur_y_q;
              vcount_q <= vcount_q + pse_pkg::IndexW'(pse_pkg::NumVerts);
              state_q  <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Segment datapath registers
  always_ff @(posedge clk_i) begin
    if (seg_start) begin
      cur_x_q <= point_i.point_x;
      cur_y_q <= point_i.point_y;
      adx_q   <= adx_c;
      ady_q   <= ady_c;
      neg_x_q <= dx_c[CW];
      neg_y_q <= dy_c[CW];
    end
    if ((state_q == StSquare) && mul_done && (dist2 == '0)) begin
      offx_q <= '0;
      offy_q <= '0;
    end
    if ((state_q == StRoot) && rdu_done) begin
      len_q <= rdu_result;
    end
    if ((state_q == StDivX) && rdu_done) begin
      offx_q <= rdu_result[pse_pkg::OffW-1:0];
    end
    if ((state_q == StDivY) && rdu_done) begin
      offy_q <= rdu_result[pse_pkg::OffW-1:0];
    end
  end

  // Output register: hold while stalled, load the next record when free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_load) begin
      out_valid_q <= 1'b1;
    end else if (record_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      if (rec_is_vert) begin
        kind_q   <= pse_pkg::KindVertex;
        vx_q     <= pse_pkg::sat_coord(sum_x);
        vy_q     <= pse_pkg::sat_coord(sum_y);
        vu_q     <= white_u_q;
        vv_q     <= white_v_q;
        vcolor_q <= color_q;
        index_q  <= '0;
        last_q   <= 1'b0;
      end else begin
        kind_q   <= pse_pkg::KindIndex;
        vx_q     <= '0;
        vy_q     <= '0;
        vu_q     <= '0;
        vv_q     <= '0;
        vcolor_q <= '0;
        index_q  <= vcount_q + pse_pkg::IndexW'(tri_k);
        last_q   <= rec_is_last;
      end
    end
  end

  assign record_o.valid           = out_valid_q;
  assign record_o.record_kind     = kind_q;
  assign record_o.vert_x          = vx_q;
  assign record_o.vert_y          = vy_q;
  assign record_o.vert_u          = vu_q;
  assign record_o.vert_v          = vv_q;
  assign record_o.vert_color      = vcolor_q;
  assign record_o.index_value     = index_q;
  assign record_o.last_of_segment = last_q;

  // The shared unit only gets a new command once the previous one has finished
  a_rdu_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rdu_cmd.root || rdu_cmd.div) |-> !rdu_busy)
    else $error("root/divide unit started while busy");

  // Offset quotient fits in OffW bits: its upper result bits are zero
  a_off_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (((state_q == StDivX) || (state_q == StDivY)) && rdu_done)
      |-> (rdu_result[pse_pkg::RootW-1:pse_pkg::OffW] == '0))
    else $error("offset quotient out of range");

  // Closing a segment advances the vertex counter by one quad
  a_vcount: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_load && rec_is_last)
      |=> (vcount_q == $past(vcount_q) + pse_pkg::IndexW'(pse_pkg::NumVerts)))
    else $error("vertex counter not advanced by four");

  // The segment end flag only ever rides on an index record
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_q) |-> (kind_q == pse_pkg::KindIndex))
    else $error("last_of_segment on a vertex record");

endmodule

// ===== dv/pse_quad_checker.sv =====
// Scoreboard for the polyline stroke expander: predicts quad records and checks each output word.
module pse_quad_checker
  import pse_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  pse_point_if                point_mon,
  pse_record_if               record_mon,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  error_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned  MaxReports   = 10;
  localparam int unsigned  LenFracShift = 14;
  localparam longint       CoordMax     = (longint'(1) << (CoordW - 1)) - 1;
  localparam longint       CoordMin     = -CoordMax - 1;
  // corner offsets of the two triangles, index record 0 in the low bits
  localparam logic [11:0]  TriCorners   = {2'd3, 2'd2, 2'd0, 2'd2, 2'd1, 2'd0};

  typedef struct packed {
    logic                     kind;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [TexW-1:0]          u;
    logic [TexW-1:0]          v;
    logic [ColorW-1:0]        color;
    logic [IndexW-1:0]        idx;
    logic                     last;
  } stroke_rec_t;

  stroke_rec_t              quad_records_q[$];

  logic [WidthW-1:0]        width_q;
  logic [ColorW-1:0]        color_q;
  logic [TexW-1:0]          white_u_q;
  logic [TexW-1:0]          white_v_q;
  logic signed [CoordW-1:0] prev_x;
  logic signed [CoordW-1:0] prev_y;
  logic                     have_prev;
  logic [IndexW-1:0]        quad_base;

  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned rem;
    longint unsigned res;
    longint unsigned probe;
    rem   = n;
    res   = 0;
    probe = longint'(1) << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= res + probe) begin
        rem = rem - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // c * width / (2 * length), rounded to nearest, ties away from zero
  function automatic longint half_width_offset(input longint c, input longint unsigned len7);
    longint unsigned mag;
    longint unsigned q;
    mag = (c < 0) ? -c : c;
    q   = (mag * longint'(width_q) * 64 + (len7 >> 1)) / len7;
    return (c < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [CoordW-1:0] clamp_coord(input longint v);
    longint r;
    r = v;
    if (v > CoordMax) r = CoordMax;
    if (v < CoordMin) r = CoordMin;
    return r[CoordW-1:0];
  endfunction

  function automatic stroke_rec_t vertex_rec(input longint x, input longint y);
    stroke_rec_t r;
    r       = '0;
    r.kind  = KindVertex;
    r.x     = clamp_coord(x);
    r.y     = clamp_coord(y);
    r.u     = white_u_q;
    r.v     = white_v_q;
    r.color = color_q;
    return r;
  endfunction

  // append one predicted word behind the ones already waiting
  function automatic void queue_rec(input stroke_rec_t r);
    quad_records_q = {quad_records_q, r};
  endfunction

  function automatic string rec_text(input stroke_rec_t r);
    return $sformatf("kind=%0d x=%0d y=%0d u=%h v=%h color=%h index=%0d last=%0d",
                     r.kind, r.x, r.y, r.u, r.v, r.color, r.idx, r.last);
  endfunction

  task automatic expand_point(input logic signed [CoordW-1:0] px,
                              input logic signed [CoordW-1:0] py, input logic begin_path);
    longint          x1, y1, x2, y2, dx, dy, ox, oy;
    longint unsigned adx, ady, dist2, len7;
    stroke_rec_t     r;
    if (begin_path || !have_prev) begin
      // latch only
      prev_x    = px;
      prev_y    = py;
      have_prev = 1'b1;
    end else begin
      x1    = prev_x;
      y1    = prev_y;
      x2    = px;
      y2    = py;
      dx    = x2 - x1;
      dy    = y2 - y1;
      adx   = (dx < 0) ? -dx : dx;
      ady   = (dy < 0) ? -dy : dy;
      dist2 = adx * adx + ady * ady;
      ox    = 0;
      oy    = 0;
      if (dist2 != 0) begin
        len7 = floor_root(dist2 << LenFracShift);
        ox   = half_width_offset(dx, len7);
        oy   = half_width_offset(dy, len7);
      end
      queue_rec(vertex_rec(x1 + oy, y1 - ox));
      queue_rec(vertex_rec(x2 + oy, y2 - ox));
      queue_rec(vertex_rec(x2 - oy, y2 + ox));
      queue_rec(vertex_rec(x1 - oy, y1 + ox));
      for (int k = 0; k < 6; k++) begin
        r      = '0;
        r.kind = KindIndex;
        r.idx  = quad_base + IndexW'(TriCorners[2*k +: 2]);
        r.last = (k == 5);
        queue_rec(r);
      end
      quad_base = quad_base + IndexW'(NumVerts);
      prev_x    = px;
      prev_y    = py;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stroke_rec_t got;
    stroke_rec_t want;
    if (!rst_ni) begin
      width_q       = 16'd256;
      color_q       = 32'hFFFF_FFFF;
      white_u_q     = '0;
      white_v_q     = '0;
      prev_x        = '0;
      prev_y        = '0;
      have_prev     = 1'b0;
      quad_base     = '0;
      error_count_o = 0;
      quad_records_q.delete();
    end else begin
      if (record_mon.valid && record_mon.ready) begin
        got.kind  = record_mon.record_kind;
        got.x     = record_mon.vert_x;
        got.y     = record_mon.vert_y;
        got.u     = record_mon.vert_u;
        got.v     = record_mon.vert_v;
        got.color = record_mon.vert_color;
        got.idx   = record_mon.index_value;
        got.last  = record_mon.last_of_segment;
        if (quad_records_q.size() == 0) begin
          error_count_o++;
          if (error_count_o <= MaxReports) $display("unexpected record: %s", rec_text(got));
        end else begin
          want = quad_records_q.pop_front();
          if (got !== want) begin
            error_count_o++;
            if (error_count_o <= MaxReports) begin
              $display("record mismatch: expected %s", rec_text(want));
              $display("                 actual   %s", rec_text(got));
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegStrokeWidth: width_q   = cfg_data_i[WidthW-1:0];
          RegStrokeColor: color_q   = cfg_data_i[ColorW-1:0];
          RegWhiteU:      white_u_q = cfg_data_i[TexW-1:0];
          RegWhiteV:      white_v_q = cfg_data_i[TexW-1:0];
          default: ;
        endcase
      end
      if (point_mon.valid && point_mon.ready) begin
        expand_point(point_mon.point_x, point_mon.point_y, point_mon.path_start);
      end
    end
    pending_o = quad_records_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the polyline stroke expander testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pse_pkg::*;

  localparam int ResetCycles   = 5;
  localparam int DrainCycles   = 160;
  localparam int QuietLimit    = 3000;
  localparam int ItemsPerPhase = 113;
  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  logic                     clk_i  = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i;
  logic [CfgIdxW-1:0]       cfg_idx_i;
  logic [CfgDataW-1:0]      cfg_data_i;
  int                       send_idle_pct  = 0;
  int                       recv_stall_pct = 0;
  int                       error_count;
  int                       records_pending;
  logic signed [CoordW-1:0] last_x;
  logic signed [CoordW-1:0] last_y;

  pse_point_if  point_ch ();
  pse_record_if record_ch ();

  polyline_stroke_expander dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .point_i    (point_ch),
    .record_o   (record_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  pse_quad_checker quad_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .point_mon     (point_ch),
    .record_mon    (record_ch),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .error_count_o (error_count),
    .pending_o     (records_pending)
  );

  always #2 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    record_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_point(input logic signed [CoordW-1:0] x, input logic signed [CoordW-1:0] y,
                            input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      point_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    point_ch.valid      <= 1'b1;
    point_ch.point_x    <= x;
    point_ch.point_y    <= y;
    point_ch.path_start <= start;
    last_x = x;
    last_y = y;
    @(posedge clk_i);
    while (!point_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // drop valid, drain all records, then idle through a trailing drain period
  task automatic settle();
    point_ch.valid <= 1'b0;
    while (records_pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] c,
                              input logic [CfgDataW-1:0] u, input logic [CfgDataW-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegStrokeWidth;
    cfg_data_i <= w;
    @(negedge clk_i);
    cfg_idx_i  <= RegStrokeColor;
    cfg_data_i <= c;
    @(negedge clk_i);
    cfg_idx_i  <= RegWhiteU;
    cfg_data_i <= u;
    @(negedge clk_i);
    cfg_idx_i  <= RegWhiteV;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic signed [CoordW-1:0] extreme_coord();
    logic signed [CoordW-1:0] r;
    case ($urandom_range(3))
      0:       r = CoordMax;
      1:       r = CoordMin;
      2:       r = '0;
      default: r = '1;
    endcase
    return r;
  endfunction

  task automatic send_random_point();
    int unsigned              roll;
    int unsigned              k;
    int                       span;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic                     start;
    roll  = $urandom_range(99);
    start = 1'b0;
    x     = CoordW'($urandom);
    y     = CoordW'($urandom);
    if (roll < 10) begin
      start = 1'b1;
    end else if (roll < 20) begin
      // full-range jump
    end else if (roll < 28) begin
      x = last_x;
      y = last_y;
    end else if (roll < 36) begin
      x = extreme_coord();
      y = extreme_coord();
    end else begin
      // continue the path with a step of random scale
      k    = $urandom_range(CoordW - 1);
      span = 1 << k;
      x    = last_x + CoordW'(int'($urandom_range(2 * span)) - span);
      y    = last_y + CoordW'(int'($urandom_range(2 * span)) - span);
    end
    send_point(x, y, start);
  endtask

  initial begin
    logic [CfgDataW-1:0] w;
    point_ch.valid      = 1'b0;
    point_ch.point_x    = '0;
    point_ch.point_y    = '0;
    point_ch.path_start = 1'b0;
    record_ch.ready     = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = RegStrokeWidth;
    cfg_data_i          = '0;
    last_x              = '0;
    last_y              = '0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: a point with no previous one, zero length, axes, far corners
    send_point('0, '0, 1'b0);
    send_point('0, '0, 1'b0);
    send_point(24'sd2560, '0, 1'b0);
    send_point(24'sd2560, 24'sd2560, 1'b0);
    send_point('1, '1, 1'b0);
    send_point(CoordMax, CoordMax, 1'b1);
    send_point(CoordMin, CoordMin, 1'b0);
    send_point(CoordMax, CoordMin, 1'b0);
    send_point(CoordMin, CoordMax, 1'b1);
    send_point(CoordMin, CoordMax - 24'sd7, 1'b0);
    send_point('1, 24'sd1, 1'b0);
    settle();

    // widest stroke, wide values into the narrow registers
    program_regs(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'hABCD_0000);
    send_point('0, '0, 1'b1);
    send_point(24'sd1, '0, 1'b0);
    send_point(CoordMax, CoordMax, 1'b0);
    send_point(CoordMax, CoordMin, 1'b0);
    send_point(24'sd3, 24'sd4, 1'b1);
    send_point('0, '0, 1'b0);
    settle();

    // zero width
    program_regs(32'h5A5A_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_FFFF);
    send_point(24'sd5, 24'sd5, 1'b1);
    send_point(24'sd100, -24'sd100, 1'b0);
    send_point(24'sd100, -24'sd100, 1'b0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 45;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 45;
        end
        default: begin
          send_idle_pct  = 32;
          recv_stall_pct = 32;
        end
      endcase
      settle();
      case ($urandom_range(3))
        0:       w = $urandom;
        1:       w = $urandom_range(1, 1024);
        2:       w = {16'($urandom), 16'hFFFF};
        default: w = {16'($urandom), 16'h0000};
      endcase
      program_regs(w, $urandom, $urandom, $urandom);
      repeat (ItemsPerPhase) send_random_point();
    end

    settle();
    if (error_count == 0 && records_pending == 0) begin
      $display("polyline_stroke_expander test passed");
    end else begin
      $display("polyline_stroke_expander test failed");
    end
    $finish;
  end

  // end the run if no word moves on either channel for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((point_ch.valid && point_ch.ready) || (record_ch.valid && record_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("polyline_stroke_expander test failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pse_pkg.sv
rtl/pse_if.sv
rtl/pse_smul.sv
rtl/pse_rdu.sv
rtl/polyline_stroke_expander.sv
dv/pse_quad_checker.sv
dv/testbench.sv
